// ===== rtl/smaq_pkg.sv =====
package smaq_pkg;

	localparam int unsigned SleepW = 24;
	localparam int unsigned CntW = 16;

	typedef enum logic [1:0] {
		REG_LED_ON_TICKS      = 2'd0,
		REG_LED_OFF_TICKS     = 2'd1,
		REG_SMOKE_HOLD_MS     = 2'd2,
		REG_MOTION_HOLDOFF_MS = 2'd3
	} reg_idx_t;

	localparam logic [CntW-1:0] LED_ON_RESET = 16'd0;
	localparam logic [CntW-1:0] LED_OFF_RESET = 16'd1000;
	localparam logic [CntW-1:0] SMOKE_HOLD_RESET = 16'd1000;
	localparam logic [CntW-1:0] MOTION_HOLDOFF_RESET = 16'd200;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic              alarm_pin;
		logic              motion_pin;
		logic [SleepW-1:0] sleep_ms;
	} in_t;

	typedef struct packed {
		logic smoke_on_event;
		logic smoke_off_event;
		logic motion_event;
		logic smoke_active;
		logic led_level;
	} out_t;

	typedef struct packed {
		logic [CntW-1:0] led_on_ticks;
		logic [CntW-1:0] led_off_ticks;
		logic [CntW-1:0] smoke_hold_ms;
		logic [CntW-1:0] motion_holdoff_ms;
	} cfg_t;

endpackage

// ===== rtl/smaq_cfg.sv =====
module smaq_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [smaq_pkg::CntW-1:0]  cfg_data,
	output smaq_pkg::cfg_t             cfg
);

	smaq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.led_on_ticks <= smaq_pkg::LED_ON_RESET;
			cfg_q.led_off_ticks <= smaq_pkg::LED_OFF_RESET;
			cfg_q.smoke_hold_ms <= smaq_pkg::SMOKE_HOLD_RESET;
			cfg_q.motion_holdoff_ms <= smaq_pkg::MOTION_HOLDOFF_RESET;
		end else if (cfg_we) begin
			unique case (smaq_pkg::reg_idx_t'(cfg_index))
				smaq_pkg::REG_LED_ON_TICKS:      cfg_q.led_on_ticks <= cfg_data;
				smaq_pkg::REG_LED_OFF_TICKS:     cfg_q.led_off_ticks <= cfg_data;
				smaq_pkg::REG_SMOKE_HOLD_MS:     cfg_q.smoke_hold_ms <= cfg_data;
				smaq_pkg::REG_MOTION_HOLDOFF_MS: cfg_q.motion_holdoff_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/smaq_core.sv =====
module smaq_core #(
	parameter int unsigned TICK_MS = 50
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  smaq_pkg::in_t  item,
	input  smaq_pkg::cfg_t cfg,
	output smaq_pkg::out_t result
);

	localparam logic [smaq_pkg::SleepW-1:0] TickSleep = smaq_pkg::SleepW'(TICK_MS);
	localparam logic [smaq_pkg::CntW-1:0] TickCnt = smaq_pkg::CntW'(TICK_MS);
	localparam logic [smaq_pkg::CntW-1:0] CntMax = '1;

	logic                        smoke_q;
	logic                        led_q;
	logic [smaq_pkg::SleepW-1:0] sleep_q;
	logic [smaq_pkg::CntW-1:0]   hold_q;
	logic [smaq_pkg::CntW-1:0]   mot_q;
	logic [smaq_pkg::CntW-1:0]   blink_q;

	logic                        smoke_d;
	logic                        led_d;
	logic [smaq_pkg::SleepW-1:0] sleep_d;
	logic [smaq_pkg::CntW-1:0]   hold_d;
	logic [smaq_pkg::CntW-1:0]   mot_d;
	logic [smaq_pkg::CntW-1:0]   blink_d;

	logic                        smoke_now;
	logic [smaq_pkg::SleepW-1:0] sleep_dn;
	logic [smaq_pkg::CntW-1:0]   hold_dn;
	logic [smaq_pkg::CntW-1:0]   mot_dn;
	logic [smaq_pkg::CntW-1:0]   blink_inc;
	logic [smaq_pkg::CntW-1:0]   limit;
	logic                        on_ev;
	logic                        off_ev;
	logic                        mot_ev;

	always_comb begin
		smoke_now = !item.alarm_pin;
		sleep_dn = (sleep_q > TickSleep) ? sleep_q - TickSleep : '0;
		hold_dn = (hold_q > TickCnt) ? hold_q - TickCnt : '0;
		mot_dn = (mot_q > TickCnt) ? mot_q - TickCnt : '0;
		blink_inc = (blink_q != CntMax) ? blink_q + 16'd1 : blink_q;
		limit = led_q ? cfg.led_on_ticks : cfg.led_off_ticks;

		smoke_d = smoke_q;
		led_d = led_q;
		sleep_d = sleep_q;
		hold_d = hold_q;
		mot_d = mot_q;
		blink_d = blink_q;
		on_ev = 1'b0;
		off_ev = 1'b0;
		mot_ev = 1'b0;

		if (item.cmd == smaq_pkg::CMD_LOAD) begin
			sleep_d = item.sleep_ms;
		end else begin
			sleep_d = sleep_dn;
			hold_d = smoke_now ? cfg.smoke_hold_ms : hold_dn;
			if (smoke_q) begin
				if (sleep_dn != '0 || hold_d == '0) begin
					smoke_d = 1'b0;
					off_ev = 1'b1;
				end
			end else if (smoke_now && sleep_dn == '0) begin
				smoke_d = 1'b1;
				on_ev = 1'b1;
			end
			mot_ev = item.motion_pin && mot_dn == '0;
			mot_d = mot_ev ? cfg.motion_holdoff_ms : mot_dn;
			if (blink_inc >= limit) begin
				led_d = !led_q;
				blink_d = '0;
			end else begin
				blink_d = blink_inc;
			end
		end

		result.smoke_on_event = on_ev;
		result.smoke_off_event = off_ev;
		result.motion_event = mot_ev;
		result.smoke_active = smoke_d;
		result.led_level = led_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoke_q <= 1'b0;
			led_q <= 1'b0;
			sleep_q <= '0;
			hold_q <= '0;
			mot_q <= '0;
			blink_q <= '0;
		end else if (fire) begin
			smoke_q <= smoke_d;
			led_q <= led_d;
			sleep_q <= sleep_d;
			hold_q <= hold_d;
			mot_q <= mot_d;
			blink_q <= blink_d;
		end
	end

endmodule

// ===== rtl/smoke_motion_alarm_qualifier.sv =====
// Smoke/motion qualifier with LED blinker. Each transfer is registered, evaluated against the
// block state once the result register is free or being drained, and written to the result
// register, so one item is taken per cycle while out_stall does not hold the result register.
// The input register and the result register lie around the single evaluation stage. in_stall
// rises only while the input register is full and the result register is held by out_stall.
// Configuration writes take effect at the next edge and belong to idle periods.
module smoke_motion_alarm_qualifier #(
	parameter int unsigned TICK_MS = 50
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  smaq_pkg::in_t             in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output smaq_pkg::out_t            out_data,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [smaq_pkg::CntW-1:0] cfg_data
);

	logic           valid_s1;
	smaq_pkg::in_t  data_s1;
	logic           valid_s2;
	smaq_pkg::out_t data_s2;
	logic           adv;
	smaq_pkg::cfg_t cfg;
	smaq_pkg::out_t result;

	assign adv = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;

	smaq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	smaq_core #(
		.TICK_MS (TICK_MS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.item   (data_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (adv) valid_s2 <= 1'b1;
			else if (!out_stall) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) data_s1 <= in_data;
		if (adv) data_s2 <= result;
	end

	assign out_valid = valid_s2;
	assign out_data = data_s2;

endmodule

// ===== rtl/smaq_checker.sv =====
module smaq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input smaq_pkg::out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_events_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.smoke_on_event && out_data.smoke_off_event))
		else $error("smoke on and off in one result");

	a_event_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_data.smoke_on_event || out_data.smoke_active) &&
			(!out_data.smoke_off_event || !out_data.smoke_active))
		else $error("smoke event disagrees with state");

	a_no_stall_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");

endmodule

bind smoke_motion_alarm_qualifier smaq_checker u_smaq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
